FILE: hw/rtl/assert_macros.svh
// assertion macros for the slope estimator rtl (included by swse_ctrl)
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define SWSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SWSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/swse_pkg.sv
// shared types and constants for the sliding window slope estimator
// no dependencies
`timescale 1ns / 1ps

package swse_pkg;

  localparam int NUM_POINTS_DEF = 8;
  localparam int TIME_STEP_W    = 16;
  localparam int SAMPLE_W       = 32;
  localparam int SLOPE_W        = 32;
  localparam int MIN_DEN_W      = 20;
  localparam int ACC_W          = 64;
  localparam int FRAC_BITS      = 16;
  localparam int Q_W            = SLOPE_W - 1;
  localparam int SAT_SHIFT      = Q_W - FRAC_BITS;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef struct packed {
    logic [TIME_STEP_W-1:0]     time_step;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic                      fit_valid;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MAC,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sum_en;
    logic mac_issue;
    logic chk;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } sts_t;

endpackage

FILE: hw/rtl/sliding_window_slope_estimator_core.sv
// sequence: a request is accepted in idle, then runs the window sum, mac walk, check and
//   divide states; the divide is skipped when the fit is rejected or saturates; one request at a time
// a new request is taken only after the result is written to a free result register slot
// reset: rst_n synchronous active low; clears window, fill count, threshold, result slot
// top level: threshold register, result register, controller and datapath
// depends on swse_pkg, swse_ctrl, swse_dp
`timescale 1ns / 1ps

module sliding_window_slope_estimator_core #(
  parameter int NUM_POINTS = swse_pkg::NUM_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  swse_pkg::in_t                  in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output swse_pkg::out_t                 out_data,
  // threshold register
  input  logic                           cfg_we,
  input  logic [swse_pkg::MIN_DEN_W-1:0] cfg_wdata
);

  // minimum denominator threshold
  logic [swse_pkg::MIN_DEN_W-1:0] min_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_den_r <= '0;
    end else if (cfg_we) begin
      min_den_r <= cfg_wdata;
    end
  end

  swse_pkg::cmd_t                cmd;
  swse_pkg::sts_t                sts;
  swse_pkg::out_t                res;
  logic [$clog2(NUM_POINTS)-1:0] idx;
  logic                          out_free;

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;

  swse_ctrl #(.NUM_POINTS(NUM_POINTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .idx_o    (idx)
  );

  swse_dp #(.NUM_POINTS(NUM_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .idx_i     (idx),
    .item_i    (in_data),
    .min_den_i (min_den_r),
    .sts_o     (sts),
    .res_o     (res)
  );

  // result register, lets the next request start while a result waits
  logic           out_valid_r;
  swse_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/swse_ctrl.sv
// controller state machine: sequences window sum, mac walk and divider
// depends on swse_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swse_ctrl #(
  parameter int NUM_POINTS = swse_pkg::NUM_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        out_free,
  input  swse_pkg::sts_t              sts_i,
  output swse_pkg::cmd_t              cmd_o,
  output logic [$clog2(NUM_POINTS)-1:0] idx_o
);

  localparam int IW      = $clog2(NUM_POINTS);
  localparam int CNT_MAX = (NUM_POINTS + 2 > swse_pkg::Q_W) ? NUM_POINTS + 2 : swse_pkg::Q_W;
  localparam int CNTW    = $clog2(CNT_MAX);

  swse_pkg::state_t st_r, st_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= swse_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      swse_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_nxt  = swse_pkg::ST_SUM;
          cnt_nxt = '0;
        end
      end
      swse_pkg::ST_SUM: begin
        if (cnt_r == CNTW'(NUM_POINTS - 1)) begin
          st_nxt  = swse_pkg::ST_MAC;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      swse_pkg::ST_MAC: begin
        if (cnt_r == CNTW'(NUM_POINTS + 1)) begin
          st_nxt  = swse_pkg::ST_CHECK;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      swse_pkg::ST_CHECK: begin
        cnt_nxt = '0;
        st_nxt  = sts_i.skip ? swse_pkg::ST_DONE : swse_pkg::ST_DIV;
      end
      swse_pkg::ST_DIV: begin
        if (cnt_r == CNTW'(swse_pkg::Q_W - 1)) begin
          st_nxt  = swse_pkg::ST_DONE;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      swse_pkg::ST_DONE: begin
        if (out_free) begin
          st_nxt = swse_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt  = swse_pkg::ST_IDLE;
        cnt_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (st_r)
      swse_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      swse_pkg::ST_SUM:   cmd_o.sum_en    = 1'b1;
      swse_pkg::ST_MAC:   cmd_o.mac_issue = (cnt_r < CNTW'(NUM_POINTS));
      swse_pkg::ST_CHECK: cmd_o.chk       = 1'b1;
      swse_pkg::ST_DIV:   cmd_o.div_step  = 1'b1;
      swse_pkg::ST_DONE:  cmd_o.finish    = out_free;
      default: cmd_o = '0;
    endcase
  end

  assign idx_o = cnt_r[IW-1:0];

  `SWSE_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command at once")
  `SWSE_ASSERT_NEXT(a_load_sum, cmd_o.load, st_r == swse_pkg::ST_SUM, "load not followed by sum")
  `SWSE_ASSERT_NEXT(a_finish_idle, cmd_o.finish, st_r == swse_pkg::ST_IDLE, "finish not idle")

endmodule

FILE: hw/rtl/swse_dp.sv
// datapath: sample window, sum and mac pipeline, restoring q16.16 divider
// depends on swse_pkg
`timescale 1ns / 1ps

module swse_dp #(
  parameter int NUM_POINTS = swse_pkg::NUM_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swse_pkg::cmd_t                  cmd_i,
  input  logic [$clog2(NUM_POINTS)-1:0]   idx_i,
  input  swse_pkg::in_t                   item_i,
  input  logic [swse_pkg::MIN_DEN_W-1:0]  min_den_i,
  output swse_pkg::sts_t                  sts_o,
  output swse_pkg::out_t                  res_o
);

  localparam int CW    = $clog2(NUM_POINTS + 1);
  localparam int TMAX  = (1 << swse_pkg::TIME_STEP_W) - 1;
  localparam int TW    = $clog2(NUM_POINTS * TMAX + 1);
  localparam int SXW   = $clog2(NUM_POINTS * NUM_POINTS * TMAX + 1);
  localparam int DW    = SXW + 1;
  localparam int YW    = swse_pkg::SAMPLE_W;
  localparam int PNW   = DW + YW;
  localparam int PDW   = DW + TW + 1;
  localparam int AW    = swse_pkg::ACC_W;
  localparam int QW    = swse_pkg::Q_W;
  localparam int SH    = swse_pkg::SAT_SHIFT;
  localparam int FB    = swse_pkg::FRAC_BITS;

  logic [TW-1:0]        th_r [NUM_POINTS];
  logic signed [YW-1:0] yv_r [NUM_POINTS];
  logic [CW-1:0]        fill_r;

  // window shift, times re-based to the oldest slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        th_r[i] <= '0;
        yv_r[i] <= '0;
      end
      fill_r <= '0;
    end else if (cmd_i.load) begin
      for (int i = 0; i < NUM_POINTS - 1; i++) begin
        th_r[i] <= th_r[i+1] - th_r[0];
        yv_r[i] <= yv_r[i+1];
      end
      th_r[NUM_POINTS-1] <= th_r[NUM_POINTS-1] - th_r[0] + TW'(item_i.time_step);
      yv_r[NUM_POINTS-1] <= item_i.sample_value;
      if (fill_r != CW'(NUM_POINTS)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  logic [TW-1:0]        x_sel;
  logic signed [YW-1:0] y_sel;
  logic                 slot_ok;

  assign x_sel   = th_r[idx_i];
  assign y_sel   = yv_r[idx_i];
  // slot belongs to the filled part of the window
  assign slot_ok = ((CW+1)'(idx_i) + (CW+1)'(fill_r)) >= (CW+1)'(NUM_POINTS);

  logic [SXW-1:0] sx_r;
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      sx_r <= '0;
    end else if (cmd_i.sum_en && slot_ok) begin
      sx_r <= sx_r + SXW'(x_sel);
    end
  end

  // stage 1: d = c*x - sx
  logic [SXW-1:0]        cx;
  logic signed [DW-1:0]  d_nxt;
  logic signed [DW-1:0]  d1_r;
  logic [TW-1:0]         x1_r;
  logic signed [YW-1:0]  y1_r;
  logic                  v1_r, v2_r;

  assign cx    = SXW'(SXW'(fill_r) * SXW'(x_sel));
  assign d_nxt = $signed({1'b0, cx}) - $signed({1'b0, sx_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd_i.mac_issue && slot_ok;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r <= d_nxt;
    x1_r <= x_sel;
    y1_r <= y_sel;
  end

  // stage 2: products
  logic signed [PNW-1:0] pn_r;
  logic signed [PDW-1:0] pd_r;
  always_ff @(posedge clk) begin
    pn_r <= PNW'(d1_r) * PNW'(y1_r);
    pd_r <= PDW'(d1_r) * $signed(PDW'({1'b0, x1_r}));
  end

  // stage 3: accumulate
  logic signed [AW-1:0] num_r, den_r;
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      num_r <= '0;
      den_r <= '0;
    end else if (v2_r) begin
      num_r <= num_r + AW'(pn_r);
      den_r <= den_r + AW'(pd_r);
    end
  end

  // threshold and overflow check
  logic          num_neg, den_neg;
  logic [AW-1:0] nmag, dmag;
  logic          den_low, big;

  assign num_neg = num_r[AW-1];
  assign den_neg = den_r[AW-1];
  assign nmag    = num_neg ? AW'(-num_r) : AW'(num_r);
  assign dmag    = den_neg ? AW'(-den_r) : AW'(den_r);
  assign den_low = dmag <= AW'(min_den_i);
  assign big     = {{SH{1'b0}}, nmag} >= {dmag, {SH{1'b0}}};
  assign sts_o.skip = den_low || big;

  logic          den_low_r, big_r, neg_r;
  logic [AW-1:0] dmag_r, rem_r;
  logic [QW-1:0] sh_r, q_r;
  logic [AW:0]   trial;
  logic          ge;

  assign trial = {rem_r, sh_r[QW-1]};
  assign ge    = trial >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (cmd_i.chk) begin
      den_low_r <= den_low;
      big_r     <= big;
      neg_r     <= num_neg ^ den_neg;
      dmag_r    <= dmag;
      rem_r     <= nmag >> SH;
      sh_r      <= {nmag[SH-1:0], {FB{1'b0}}};
      q_r       <= '0;
    end else if (cmd_i.div_step) begin
      rem_r <= ge ? AW'(trial - {1'b0, dmag_r}) : trial[AW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      sh_r  <= {sh_r[QW-2:0], 1'b0};
    end
  end

  always_comb begin
    res_o.fit_valid = !den_low_r;
    if (den_low_r) begin
      res_o.slope = '0;
    end else if (big_r) begin
      res_o.slope = neg_r ? swse_pkg::SLOPE_MIN : swse_pkg::SLOPE_MAX;
    end else if (neg_r) begin
      res_o.slope = swse_pkg::SLOPE_W'(-{1'b0, q_r});
    end else begin
      res_o.slope = swse_pkg::SLOPE_W'({1'b0, q_r});
    end
  end

endmodule
